@@ src/smcsr_pkg.sv @@
// Shared types and constants for the sparse matrix store in CSR form.
// Used by the entry cell, the row-start cell and the top level; no dependencies.
package smcsr_pkg;

  localparam int CoordWidth = 6;
  localparam int DimRegWidth = 7;
  localparam int IoValueWidth = 32;

  // Command and result beats.
  typedef struct packed {
    logic                           operation;
    logic [CoordWidth-1:0]          row;
    logic [CoordWidth-1:0]          col;
    logic signed [IoValueWidth-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic signed [IoValueWidth-1:0] read_value;
    logic [1:0]                     status;
  } res_t;

  // Operation codes.
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Status codes.
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusRange = 2'd1;
  localparam logic [1:0] StatusFull  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CfgRowTotal    = 2'd0;
  localparam logic [1:0] CfgColumnTotal = 2'd1;
  localparam logic [1:0] CfgTransposed  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_LOAD,
    ST_ROW_SHIFT,
    ST_BOUNDS,
    ST_ENT_LOAD,
    ST_ENT_SHIFT,
    ST_APPLY
  } state_t;

  // Controls broadcast to every row-start cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic adj_up;
    logic adj_dn;
  } row_ctl_t;

  // Controls broadcast to every entry cell.
  typedef struct packed {
    logic load;
    logic shift;
    logic ins;
    logic rem;
    logic upd;
  } ent_ctl_t;

endpackage

@@ src/smcsr_cell.sv @@
// One entry cell of the packed entry store: column, value and a result carry.
// Depends on smcsr_pkg.
module smcsr_cell #(
  parameter int Index = 0,
  parameter int StartWidth = 9,
  parameter int ValueWidth = 32
) (
  input  logic                              clk,
  input  smcsr_pkg::ent_ctl_t               ctl,
  input  logic [StartWidth-1:0]             lo,
  input  logic [StartWidth-1:0]             hi,
  input  logic [smcsr_pkg::CoordWidth-1:0]  c,
  input  logic [ValueWidth-1:0]             v,
  input  logic                              ge_prev,
  output logic                              ge,
  input  logic [smcsr_pkg::CoordWidth-1:0]  prev_col,
  input  logic [ValueWidth-1:0]             prev_val,
  input  logic [smcsr_pkg::CoordWidth-1:0]  next_col,
  input  logic [ValueWidth-1:0]             next_val,
  output logic [smcsr_pkg::CoordWidth-1:0]  col,
  output logic [ValueWidth-1:0]             val,
  input  logic [ValueWidth:0]               car_in,
  output logic [ValueWidth:0]               car
);
  import smcsr_pkg::*;

  localparam logic [StartWidth-1:0] MyIndex = StartWidth'(Index);

  logic is_pos;
  logic found_here;

  // Columns are sorted within a row, so the flags rise once along the chain.
  assign ge = (MyIndex >= hi) || ((MyIndex >= lo) && (col >= c));
  assign is_pos = ge && !ge_prev;
  assign found_here = (MyIndex < hi) && (col == c);

  // Entry payload: insert shifts up, removal shifts down, update overwrites.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (is_pos) begin
        col <= c;
        val <= v;
      end else if (ge) begin
        col <= prev_col;
        val <= prev_val;
      end
    end else if (ctl.rem) begin
      if (ge) begin
        col <= next_col;
        val <= next_val;
      end
    end else if (ctl.upd && is_pos) begin
      val <= v;
    end
  end

  // Result carry: the addressed cell loads, then the carry moves toward cell zero.
  // At most one cell loads a nonzero carry, so merging keeps it once it arrives.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      car <= is_pos ? {found_here, val} : '0;
    end else if (ctl.shift) begin
      car <= car | car_in;
    end
  end

endmodule

@@ src/smcsr_row.sv @@
// One row-start cell: holds a row start and carries bound values toward cell zero.
// Depends on smcsr_pkg.
module smcsr_row #(
  parameter int Index = 0,
  parameter int StartWidth = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  smcsr_pkg::row_ctl_t              ctl,
  input  logic [smcsr_pkg::CoordWidth-1:0] r,
  input  logic [StartWidth-1:0]            lo_in,
  input  logic [StartWidth-1:0]            hi_in,
  output logic [StartWidth-1:0]            start_val,
  output logic [StartWidth-1:0]            lo_car,
  output logic [StartWidth-1:0]            hi_car
);
  import smcsr_pkg::*;

  logic above;
  assign above = Index > int'(r);

  // Row start: adjusted when an entry of an earlier row comes or goes.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_val <= '0;
    end else if (ctl.adj_up && above) begin
      start_val <= start_val + 1'b1;
    end else if (ctl.adj_dn && above && (start_val != '0)) begin
      start_val <= start_val - 1'b1;
    end
  end

  // Bound carries for the start of row r and of row r+1. Only one cell loads
  // each bound, so merging the incoming carry keeps it once it reaches cell zero.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lo_car <= (Index == int'(r)) ? start_val : '0;
      hi_car <= (Index == int'(r) + 1) ? start_val : '0;
    end else if (ctl.shift) begin
      lo_car <= lo_car | lo_in;
      hi_car <= hi_car | hi_in;
    end
  end

endmodule

@@ src/sparse_matrix_csr_store.sv @@
// Top level of the sparse matrix store in CSR form: sequencer and cell chains.
// Depends on smcsr_pkg, smcsr_row and smcsr_cell.
//
//   channel   handshake                 payload
//   command   start / busy              cmd (operation, row, col, write_value)
//   result    result_valid strobe       result (read_value, status)
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A command in range keeps busy high while the row-start chain shifts its bounds
// out toward cell zero and then the entry chain shifts the addressed entry out.
// Its result beat follows in the next cycle, in which a new command may already
// be accepted. An out-of-range command is busy only for the APPLY state. Reset
// clears all row starts at once; entries need no clearing. The result strobe
// lasts one cycle and cannot be stalled.
module sparse_matrix_csr_store #(
  parameter int MAX_DIM = 64,
  parameter int MAX_ENTRIES = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  smcsr_pkg::cmd_t                      cmd,
  output logic                                 result_valid,
  output smcsr_pkg::res_t                      result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [smcsr_pkg::DimRegWidth-1:0]    cfg_data
);
  import smcsr_pkg::*;

  localparam int StartWidth = $clog2(MAX_ENTRIES + 1);
  localparam int CountWidth = $clog2(MAX_DIM + MAX_ENTRIES + 1);
  localparam logic [StartWidth-1:0] EntryLimit = StartWidth'(MAX_ENTRIES);

  // Configuration registers.
  logic [DimRegWidth-1:0] row_total;
  logic [DimRegWidth-1:0] column_total;
  logic                   transposed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_total <= DimRegWidth'(64);
      column_total <= DimRegWidth'(64);
      transposed <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgRowTotal:    row_total <= cfg_data;
        CfgColumnTotal: column_total <= cfg_data;
        CfgTransposed:  transposed <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Latched command.
  logic                  op;
  logic [CoordWidth-1:0] r;
  logic [CoordWidth-1:0] c;
  logic [VALUE_WIDTH-1:0] v;
  logic                  in_range;
  logic [StartWidth-1:0] lo;
  logic [StartWidth-1:0] hi;

  logic [CoordWidth-1:0] r_in;
  logic [CoordWidth-1:0] c_in;
  logic [63:0]           wv_wide;
  logic                  range_in;

  assign r_in = transposed ? cmd.col : cmd.row;
  assign c_in = transposed ? cmd.row : cmd.col;
  assign wv_wide = 64'(unsigned'(cmd.write_value));
  assign range_in = (int'(r_in) < int'(row_total)) && (int'(r_in) < MAX_DIM) &&
                    (int'(c_in) < int'(column_total)) && (int'(c_in) < MAX_DIM);

  // Sequencer.
  state_t state;
  state_t state_next;
  logic [CountWidth-1:0] cnt;
  logic [CountWidth-1:0] cnt_next;
  row_ctl_t row_ctl;
  ent_ctl_t ent_ctl;
  logic accept;

  assign accept = start && !busy;
  assign busy = state != ST_IDLE;

  // Chains.
  logic [StartWidth-1:0] starts [MAX_DIM+1];
  logic [StartWidth-1:0] lo_cars [MAX_DIM+2];
  logic [StartWidth-1:0] hi_cars [MAX_DIM+2];
  logic                  ges [MAX_ENTRIES+1];
  logic [CoordWidth-1:0] cols [MAX_ENTRIES+2];
  logic [VALUE_WIDTH-1:0] vals [MAX_ENTRIES+2];
  logic [VALUE_WIDTH:0]  cars [MAX_ENTRIES+1];

  assign lo_cars[MAX_DIM+1] = '0;
  assign hi_cars[MAX_DIM+1] = '0;
  assign ges[0] = 1'b0;
  assign cars[MAX_ENTRIES] = '0;
  assign cols[0] = '0;
  assign vals[0] = '0;
  assign cols[MAX_ENTRIES+1] = cols[MAX_ENTRIES];
  assign vals[MAX_ENTRIES+1] = vals[MAX_ENTRIES];

  genvar gi;
  generate
    for (gi = 0; gi <= MAX_DIM; gi++) begin : g_row
      smcsr_row #(.Index(gi), .StartWidth(StartWidth)) u_row (
        .clk      (clk),
        .rst      (rst),
        .ctl      (row_ctl),
        .r        (r),
        .lo_in    (lo_cars[gi+1]),
        .hi_in    (hi_cars[gi+1]),
        .start_val(starts[gi]),
        .lo_car   (lo_cars[gi]),
        .hi_car   (hi_cars[gi])
      );
    end
    // Entry cell i sits at slot i+1 of the column and value arrays.
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_ent
      smcsr_cell #(.Index(gi), .StartWidth(StartWidth), .ValueWidth(VALUE_WIDTH)) u_cell (
        .clk     (clk),
        .ctl     (ent_ctl),
        .lo      (lo),
        .hi      (hi),
        .c       (c),
        .v       (v),
        .ge_prev (ges[gi]),
        .ge      (ges[gi+1]),
        .prev_col(cols[gi]),
        .prev_val(vals[gi]),
        .next_col(cols[gi+2]),
        .next_val(vals[gi+2]),
        .col     (cols[gi+1]),
        .val     (vals[gi+1]),
        .car_in  (cars[gi+1]),
        .car     (cars[gi])
      );
    end
  endgenerate

  // Bounds of the addressed row, kept within the entry count.
  logic [StartWidth-1:0] n_cnt;
  logic [StartWidth-1:0] e_b;
  logic [StartWidth-1:0] s_b;

  assign n_cnt = (starts[MAX_DIM] > EntryLimit) ? EntryLimit : starts[MAX_DIM];
  assign e_b = (hi_cars[0] > n_cnt) ? n_cnt : hi_cars[0];
  assign s_b = (lo_cars[0] > e_b) ? e_b : lo_cars[0];

  // Write decision from the carried result.
  logic found;
  logic v_zero;
  logic full;
  logic do_write;

  assign found = cars[0][VALUE_WIDTH];
  assign v_zero = v == '0;
  assign full = n_cnt >= EntryLimit;
  assign do_write = (state == ST_APPLY) && in_range && (op == OpWrite);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    row_ctl = '0;
    ent_ctl = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = range_in ? ST_ROW_LOAD : ST_APPLY;
        end
      end
      ST_ROW_LOAD: begin
        row_ctl.load = 1'b1;
        cnt_next = '0;
        state_next = ST_ROW_SHIFT;
      end
      ST_ROW_SHIFT: begin
        row_ctl.shift = 1'b1;
        cnt_next = cnt + 1'b1;
        if (int'(cnt) == MAX_DIM - 1) begin
          state_next = ST_BOUNDS;
        end
      end
      ST_BOUNDS: begin
        state_next = ST_ENT_LOAD;
      end
      ST_ENT_LOAD: begin
        ent_ctl.load = 1'b1;
        cnt_next = '0;
        state_next = (MAX_ENTRIES > 1) ? ST_ENT_SHIFT : ST_APPLY;
      end
      ST_ENT_SHIFT: begin
        ent_ctl.shift = 1'b1;
        cnt_next = cnt + 1'b1;
        if (int'(cnt) >= MAX_ENTRIES - 2) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (do_write) begin
          if (v_zero) begin
            ent_ctl.rem = found;
            row_ctl.adj_dn = found;
          end else if (found) begin
            ent_ctl.upd = 1'b1;
          end else if (!full) begin
            ent_ctl.ins = 1'b1;
            row_ctl.adj_up = 1'b1;
          end
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // Command and bound registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= cmd.operation;
      r <= r_in;
      c <= c_in;
      v <= wv_wide[VALUE_WIDTH-1:0];
      in_range <= range_in;
    end
    if (state == ST_BOUNDS) begin
      lo <= s_b;
      hi <= e_b;
    end
  end

  // Result beat.
  logic [63:0] rv_wide;
  assign rv_wide = 64'(cars[0][VALUE_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= state == ST_APPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      result.read_value <= '0;
      result.status <= StatusOk;
      if (!in_range) begin
        if (op == OpWrite) begin
          result.status <= StatusRange;
        end
      end else if (op == OpRead) begin
        if (found) begin
          result.read_value <= signed'(rv_wide[IoValueWidth-1:0]);
        end
      end else if (!v_zero && !found && full) begin
        result.status <= StatusFull;
      end
    end
  end

endmodule

@@ sim/csr_store_checker.sv @@
// Checker for the CSR sparse matrix store: keeps its own copy of the matrix,
// predicts every result beat and compares it. Depends on smcsr_pkg.
`timescale 1ns / 100ps

module csr_store_checker
  import smcsr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  cmd_t                   cmd,
  input  logic                   result_valid,
  input  res_t                   result,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [DimRegWidth-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int DimLimit = 64;
  localparam int EntryLimit = 256;

  int          starts_tbl [DimLimit+1];
  logic [5:0]  col_tbl [EntryLimit];
  logic [31:0] val_tbl [EntryLimit];
  logic [6:0]  rows_reg, cols_reg;
  logic        swap_reg;
  res_t        expected_q [$];

  assign pending_count = expected_q.size();

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input res_t got, input res_t want);
    $display("MISMATCH %s: got value %0d status %0d, want value %0d status %0d",
             what, got.read_value, got.status, want.read_value, want.status);
    fail_count++;
  endtask

  // Apply one command to the matrix copy and return the result it gives.
  function automatic res_t apply_cmd(input cmd_t c);
    res_t        res;
    int          r, k, rows, cols, n, lo, hi, pos;
    bit          found;
    r = c.row;
    k = c.col;
    rows = (rows_reg > DimLimit) ? DimLimit : rows_reg;
    cols = (cols_reg > DimLimit) ? DimLimit : cols_reg;
    if (swap_reg) begin
      r = c.col;
      k = c.row;
    end
    res = '0;
    if (r >= rows || k >= cols) begin
      if (c.operation == OpWrite) res.status = StatusRange;
      return res;
    end
    n = (starts_tbl[DimLimit] > EntryLimit) ? EntryLimit : starts_tbl[DimLimit];
    hi = (starts_tbl[r+1] > n) ? n : starts_tbl[r+1];
    lo = (starts_tbl[r] > hi) ? hi : starts_tbl[r];
    pos = lo;
    while (pos < hi && col_tbl[pos] < k) pos++;
    found = (pos < hi) && (col_tbl[pos] == k);
    if (c.operation == OpRead) begin
      if (found) res.read_value = val_tbl[pos];
      return res;
    end
    if (c.write_value == 0) begin
      if (found) begin
        for (int i = pos; i + 1 < n; i++) begin
          col_tbl[i] = col_tbl[i+1];
          val_tbl[i] = val_tbl[i+1];
        end
        for (int i = r + 1; i <= DimLimit; i++)
          if (starts_tbl[i] > 0) starts_tbl[i]--;
      end
    end else if (found) begin
      val_tbl[pos] = c.write_value;
    end else if (n >= EntryLimit) begin
      res.status = StatusFull;
    end else begin
      for (int i = n; i > pos; i--) begin
        col_tbl[i] = col_tbl[i-1];
        val_tbl[i] = val_tbl[i-1];
      end
      col_tbl[pos] = 6'(k);
      val_tbl[pos] = c.write_value;
      for (int i = r + 1; i <= DimLimit; i++) starts_tbl[i]++;
    end
    return res;
  endfunction

  // Watch all three channels at each edge.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i <= DimLimit; i++) starts_tbl[i] = 0;
      rows_reg <= 7'd64;
      cols_reg <= 7'd64;
      swap_reg <= 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", result, '0);
        end else begin
          want = expected_q.pop_front();
          if (result.read_value !== want.read_value) report_mismatch("read_value", result, want);
          else if (result.status !== want.status) report_mismatch("status", result, want);
        end
      end
      if (start && !busy) expected_q.push_back(apply_cmd(cmd));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgRowTotal: begin
            rows_reg <= cfg_data;
          end
          CfgColumnTotal: begin
            cols_reg <= cfg_data;
          end
          CfgTransposed: begin
            swap_reg <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

@@ sim/tb_sparse_matrix_csr_store.sv @@
// Testbench top for the CSR sparse matrix store: drives commands and register
// writes and gives the verdict. Depends on smcsr_pkg and csr_store_checker.
`timescale 1ns / 100ps

module tb_sparse_matrix_csr_store;
  import smcsr_pkg::*;

  localparam int CmdCycles = 64 + 256 + 5;
  localparam longint CycleLimit = 6_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd = '0;
  logic             result_valid;
  res_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = CfgRowTotal;
  logic [6:0]       cfg_data = '0;
  int               fail_count, pending_count;
  longint           cycle_count = 0;

  always #1 clk = ~clk;

  sparse_matrix_csr_store dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  csr_store_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random gap between beats, mostly short, sometimes long. The extra edge keeps
  // the release of start and the next beat in different time steps.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n + 1) @(posedge clk);
  endtask

  // Send one command beat and wait for it to be taken.
  task automatic send_cmd(input logic op, input logic [5:0] r, input logic [5:0] c,
                          input logic [31:0] v);
    start <= 1'b1;
    cmd <= '{operation: op, row: r, col: c, write_value: v};
    do @(posedge clk); while (busy);
    start <= 1'b0;
    idle_gap();
  endtask

  // Wait until the block is idle, then write one register.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    while (pending_count != 0) @(posedge clk);
    repeat (CmdCycles + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // Random phase in a window of the matrix; writes dominate so the store fills.
  task automatic random_phase(input int count, input int span, input int zero_pct);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      v = ($urandom_range(0, 99) < zero_pct) ? 32'd0 : rand_value();
      send_cmd($urandom_range(0, 2) != 0, 6'($urandom_range(0, span)),
               6'($urandom_range(0, span)), v);
      if (i == count / 2 && $urandom_range(0, 1) == 0)
        while (pending_count != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, update, removal, absent removal, reads.
    send_cmd(OpWrite, 6'd0, 6'd0, 32'h8000_0000);
    send_cmd(OpWrite, 6'd63, 6'd63, 32'h7FFF_FFFF);
    send_cmd(OpWrite, 6'd0, 6'd63, 32'hFFFF_FFFF);
    send_cmd(OpWrite, 6'd63, 6'd0, 32'h0000_0001);
    send_cmd(OpRead, 6'd0, 6'd0, 32'd0);
    send_cmd(OpRead, 6'd63, 6'd63, 32'hFFFF_FFFF);
    send_cmd(OpWrite, 6'd0, 6'd0, 32'h1234_5678);
    send_cmd(OpRead, 6'd0, 6'd0, 32'd0);
    send_cmd(OpWrite, 6'd0, 6'd63, 32'd0);
    send_cmd(OpWrite, 6'd5, 6'd5, 32'd0);
    send_cmd(OpRead, 6'd0, 6'd63, 32'd0);
    send_cmd(OpRead, 6'd63, 6'd0, 32'd0);

    // Hold off until the block has drained.
    while (pending_count != 0) @(posedge clk);

    // Small matrix: out-of-range reads and writes.
    write_reg(CfgRowTotal, 7'd4);
    write_reg(CfgColumnTotal, 7'd3);
    send_cmd(OpWrite, 6'd4, 6'd0, 32'd7);
    send_cmd(OpWrite, 6'd0, 6'd3, 32'd7);
    send_cmd(OpRead, 6'd63, 6'd0, 32'd0);
    send_cmd(OpWrite, 6'd3, 6'd2, 32'd9);
    random_phase(60, 5, 30);

    // Transposed access over the same small matrix.
    write_reg(CfgTransposed, 7'h7F);
    send_cmd(OpRead, 6'd2, 6'd3, 32'd0);
    random_phase(60, 5, 30);

    // Zero-sized matrix, and sizes above the maximum.
    write_reg(CfgRowTotal, 7'd0);
    random_phase(20, 63, 20);
    write_reg(CfgRowTotal, 7'd127);
    write_reg(CfgColumnTotal, 7'd127);
    write_reg(CfgTransposed, 7'd0);

    // Fill the store past its capacity, then churn it.
    random_phase(380, 63, 3);
    random_phase(200, 63, 40);
    write_reg(CfgColumnTotal, 7'd64);
    write_reg(CfgTransposed, 7'd1);
    random_phase(100, 63, 50);

    // Drain and settle.
    while (pending_count != 0) @(posedge clk);
    repeat (CmdCycles + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
